@@ src/mfp_pkg.sv @@
// shared types, constants and the pin-to-source map for the interrupt controller
// depends on nothing; the design files refer to it by scoped names, the testbench imports it
package mfp_pkg;

	localparam int SRC_COUNT = 16;
	localparam int SRC_W     = 4;
	localparam int PIN_COUNT = 8;
	localparam int PIN_W     = 3;
	localparam int TIME_W    = 32;
	localparam int GUARD_W   = 8;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam logic [2:0] IPL_LIMIT = 3'd6;

	// request kinds carried in req_type
	typedef enum logic [1:0] {
		REQ_PIN   = 2'd0,
		REQ_INT   = 2'd1,
		REQ_CHECK = 2'd2,
		REQ_CLEAR = 2'd3
	} mfp_req_t;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_ACTIVE_EDGE = 3'd0,
		REG_PIN_DIR     = 3'd1,
		REG_IRQ_ENABLE  = 3'd2,
		REG_IRQ_MASK    = 3'd3,
		REG_VECTOR_BASE = 3'd4,
		REG_SOFT_EOI    = 3'd5,
		REG_ACK_GUARD   = 3'd6,
		REG_NONE        = 3'd7
	} mfp_reg_t;

	typedef struct packed {
		logic [PIN_COUNT-1:0] active_edge;
		logic [PIN_COUNT-1:0] pin_direction;
		logic [SRC_COUNT-1:0] interrupt_enable;
		logic [SRC_COUNT-1:0] interrupt_mask;
		logic [3:0]           vector_base;
		logic                 software_eoi;
		logic [GUARD_W-1:0]   ack_guard_cycles;
	} mfp_cfg_t;

	// step information broadcast to every cell
	typedef struct packed {
		logic              take;
		mfp_req_t          kind;
		logic [SRC_W-1:0]  irq_number;
		logic              deliver_ok;
		logic              guard_ok;
		logic              soft_eoi;
		logic [TIME_W-1:0] now_time;
	} mfp_bcast_t;

	// priority chain handed from a cell to the one below it
	typedef struct packed {
		logic no_isr;
		logic scan;
	} mfp_link_t;

	// what a cell reports for the current beat
	typedef struct packed {
		logic fire;
		logic pend_nx;
		logic isr_nx;
	} mfp_cell_out_t;

	// gpip pin to interrupt source
	function automatic logic [SRC_W-1:0] pin_source(input logic [PIN_W-1:0] pin);
		logic [SRC_W-1:0] s;
		case (pin)
			3'd0:    s = 4'd0;
			3'd1:    s = 4'd1;
			3'd2:    s = 4'd2;
			3'd3:    s = 4'd3;
			3'd4:    s = 4'd6;
			3'd5:    s = 4'd7;
			3'd6:    s = 4'd14;
			3'd7:    s = 4'd15;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

@@ src/mfp_if.sv @@
// request and result channels of the interrupt controller
// depends on mfp_pkg for field widths
interface mfp_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    req_type;
	logic [mfp_pkg::PIN_W-1:0]     pin_index;
	logic                          pin_level;
	logic [mfp_pkg::SRC_W-1:0]     irq_number;
	logic [2:0]                    cpu_ipl;
	logic                          mfp_hold;
	logic [mfp_pkg::TIME_W-1:0]    now_time;
	logic [mfp_pkg::SRC_COUNT-1:0] clear_mask;

	modport source (output valid, req_type, pin_index, pin_level, irq_number, cpu_ipl,
		mfp_hold, now_time, clear_mask, input ready);
	modport sink (input valid, req_type, pin_index, pin_level, irq_number, cpu_ipl,
		mfp_hold, now_time, clear_mask, output ready);
endinterface

interface mfp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          irq_fired;
	logic [7:0]                    vector_number;
	logic [mfp_pkg::SRC_COUNT-1:0] pending_bits;
	logic [mfp_pkg::SRC_COUNT-1:0] in_service_bits;

	modport source (output valid, irq_fired, vector_number, pending_bits, in_service_bits,
		input ready);
	modport sink (input valid, irq_fired, vector_number, pending_bits, in_service_bits,
		output ready);
endinterface

@@ src/mfp_cfg.sv @@
// apb-style configuration registers of the interrupt controller
// depends on mfp_pkg
module mfp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfp_pkg::ADDR_W-1:0]   paddr,
	input  logic [mfp_pkg::DATA_W-1:0]   pwdata,
	output logic [mfp_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output mfp_pkg::mfp_cfg_t            cfg
);

	mfp_pkg::mfp_cfg_t cfg_q;
	mfp_pkg::mfp_reg_t idx;
	logic              wr;

	assign idx    = mfp_pkg::mfp_reg_t'(paddr[mfp_pkg::ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes, excess bits dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				mfp_pkg::REG_ACTIVE_EDGE: cfg_q.active_edge      <= pwdata[7:0];
				mfp_pkg::REG_PIN_DIR:     cfg_q.pin_direction    <= pwdata[7:0];
				mfp_pkg::REG_IRQ_ENABLE:  cfg_q.interrupt_enable <= pwdata[15:0];
				mfp_pkg::REG_IRQ_MASK:    cfg_q.interrupt_mask   <= pwdata[15:0];
				mfp_pkg::REG_VECTOR_BASE: cfg_q.vector_base      <= pwdata[3:0];
				mfp_pkg::REG_SOFT_EOI:    cfg_q.software_eoi     <= pwdata[0];
				mfp_pkg::REG_ACK_GUARD:   cfg_q.ack_guard_cycles <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			mfp_pkg::REG_ACTIVE_EDGE: prdata = {24'd0, cfg_q.active_edge};
			mfp_pkg::REG_PIN_DIR:     prdata = {24'd0, cfg_q.pin_direction};
			mfp_pkg::REG_IRQ_ENABLE:  prdata = {16'd0, cfg_q.interrupt_enable};
			mfp_pkg::REG_IRQ_MASK:    prdata = {16'd0, cfg_q.interrupt_mask};
			mfp_pkg::REG_VECTOR_BASE: prdata = {28'd0, cfg_q.vector_base};
			mfp_pkg::REG_SOFT_EOI:    prdata = {31'd0, cfg_q.software_eoi};
			mfp_pkg::REG_ACK_GUARD:   prdata = {24'd0, cfg_q.ack_guard_cycles};
			default:                  prdata = '0;
		endcase
	end

endmodule

@@ src/mfp_gpip.sv @@
// gpip level store and edge detector; turns an active pin edge into a pend request
// depends on mfp_pkg
module mfp_gpip (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [mfp_pkg::PIN_W-1:0]     pin_index,
	input  logic                          pin_level,
	input  mfp_pkg::mfp_cfg_t             cfg,
	output logic [mfp_pkg::SRC_COUNT-1:0] pin_set
);

	logic [mfp_pkg::PIN_COUNT-1:0] levels_q;
	logic                          cur;
	logic                          changed;
	logic                          active;
	logic [mfp_pkg::SRC_W-1:0]     src;

	assign cur     = levels_q[pin_index];
	assign changed = cur != pin_level;
	// rising edge triggers when active_edge is 1, falling when 0
	assign active  = changed && (cur != cfg.active_edge[pin_index])
		&& !cfg.pin_direction[pin_index];
	assign src     = mfp_pkg::pin_source(pin_index);

	always_comb begin
		pin_set = '0;
		pin_set[src] = take && active && cfg.interrupt_enable[src];
	end

	// track pin levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= '0;
		end else if (take && changed) begin
			levels_q[pin_index] <= pin_level;
		end
	end

endmodule

@@ src/mfp_cell.sv @@
// one interrupt source: pending, in-service and last service time
// depends on mfp_pkg; sits in a priority chain from source 15 down to 0
module mfp_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mfp_pkg::SRC_W-1:0]     idx,
	input  mfp_pkg::mfp_bcast_t           bc,
	input  logic                          en,
	input  logic                          mask,
	input  logic                          pin_set,
	input  logic                          clr,
	input  mfp_pkg::mfp_link_t            link_in,
	output mfp_pkg::mfp_link_t            link_out,
	output mfp_pkg::mfp_cell_out_t        co,
	output logic [mfp_pkg::TIME_W-1:0]    last_time
);

	logic                        pend_q;
	logic                        isr_q;
	logic [mfp_pkg::TIME_W-1:0]  time_q;
	logic                        self;
	logic                        pend_eff;
	logic                        fire_int;
	logic                        fire_chk;
	logic                        fire;

	assign self = bc.irq_number == idx;

	// internal request re-pends only once the guard time has passed
	assign pend_eff = pend_q
		|| (bc.kind == mfp_pkg::REQ_INT && self && en && bc.guard_ok);

	// pass the chain on to lower priorities
	assign link_out.no_isr = link_in.no_isr && !isr_q;
	assign link_out.scan   = link_in.scan && !isr_q && !(pend_q && mask);

	assign fire_int = bc.kind == mfp_pkg::REQ_INT && self && en && pend_eff && mask
		&& link_in.no_isr && !isr_q;
	assign fire_chk = bc.kind == mfp_pkg::REQ_CHECK && link_in.scan && !isr_q
		&& pend_q && mask && en;
	assign fire     = bc.take && bc.deliver_ok && (fire_int || fire_chk);

	// next state of this source
	always_comb begin
		co.fire    = fire;
		co.pend_nx = pend_q;
		co.isr_nx  = isr_q;
		case (bc.kind)
			mfp_pkg::REQ_PIN:   co.pend_nx = pend_q || pin_set;
			mfp_pkg::REQ_INT:   co.pend_nx = pend_eff;
			mfp_pkg::REQ_CLEAR: co.isr_nx  = isr_q && !clr;
			default: ;
		endcase
		if (fire) begin
			co.pend_nx = 1'b0;
			co.isr_nx  = bc.soft_eoi;
		end
	end

	assign last_time = time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			isr_q  <= 1'b0;
			time_q <= '0;
		end else if (bc.take) begin
			pend_q <= co.pend_nx;
			isr_q  <= co.isr_nx;
			if (fire) begin
				time_q <= bc.now_time;
			end
		end
	end

endmodule

@@ src/mfp_interrupt_controller.sv @@
// Sixteen-source prioritised interrupt controller with an eight-pin gpip edge
// detector. A new request beat is accepted each cycle while the result
// register is empty or being drained, so the sustained rate is one beat per
// cycle; each beat yields exactly one result beat, registered in the following
// cycle. The priority decision ripples combinationally through a chain of
// sixteen source cells from source 15 down to 0, and the guard check of an
// internal request is one 32-bit subtract and compare on the addressed cell's
// last service time. Registers sit on the apb port at byte address 4*i.
// depends on mfp_pkg, mfp_if, mfp_cfg, mfp_gpip and mfp_cell
module mfp_interrupt_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mfp_pkg::ADDR_W-1:0]  paddr,
	input  logic [mfp_pkg::DATA_W-1:0]  pwdata,
	output logic [mfp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	mfp_req_if.sink                     req,
	mfp_rsp_if.source                   rsp
);

	mfp_pkg::mfp_cfg_t                  cfg;
	mfp_pkg::mfp_bcast_t                bc;
	mfp_pkg::mfp_link_t                 link [mfp_pkg::SRC_COUNT+1];
	mfp_pkg::mfp_cell_out_t             co   [mfp_pkg::SRC_COUNT];
	logic [mfp_pkg::TIME_W-1:0]         ltime [mfp_pkg::SRC_COUNT];
	logic [mfp_pkg::SRC_COUNT-1:0]      pin_set;
	logic [mfp_pkg::SRC_COUNT-1:0]      fire;
	logic [mfp_pkg::SRC_COUNT-1:0]      pend_nx;
	logic [mfp_pkg::SRC_COUNT-1:0]      isr_nx;
	logic [mfp_pkg::SRC_W-1:0]          fire_idx;
	logic                               take;
	logic [mfp_pkg::TIME_W-1:0]         diff;
	logic [mfp_pkg::TIME_W-1:0]         mag;
	logic                               valid_q;
	logic                               fired_q;
	logic [7:0]                         vector_q;
	logic [mfp_pkg::SRC_COUNT-1:0]      pend_q;
	logic [mfp_pkg::SRC_COUNT-1:0]      isr_q;

	mfp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// accept while the result register is free or being taken
	assign req.ready = !valid_q || rsp.ready;
	assign take      = req.valid && req.ready;

	mfp_gpip u_gpip (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take && mfp_pkg::mfp_req_t'(req.req_type) == mfp_pkg::REQ_PIN),
		.pin_index (req.pin_index),
		.pin_level (req.pin_level),
		.cfg       (cfg),
		.pin_set   (pin_set)
	);

	// guard distance: magnitude of the wrapping difference against the guard
	assign diff = req.now_time - ltime[req.irq_number];
	assign mag  = diff[mfp_pkg::TIME_W-1] ? (~diff + 32'd1) : diff;

	assign bc.take       = take;
	assign bc.kind       = mfp_pkg::mfp_req_t'(req.req_type);
	assign bc.irq_number = req.irq_number;
	assign bc.deliver_ok = req.cpu_ipl < mfp_pkg::IPL_LIMIT && !req.mfp_hold;
	assign bc.guard_ok   = mag >= {{(mfp_pkg::TIME_W-mfp_pkg::GUARD_W){1'b0}},
		cfg.ack_guard_cycles};
	assign bc.soft_eoi   = cfg.software_eoi;
	assign bc.now_time   = req.now_time;

	// chain head: nothing in service above the top source
	assign link[mfp_pkg::SRC_COUNT] = '{no_isr: 1'b1, scan: 1'b1};

	for (genvar i = 0; i < mfp_pkg::SRC_COUNT; i++) begin : g_cell
		mfp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (mfp_pkg::SRC_W'(i)),
			.bc        (bc),
			.en        (cfg.interrupt_enable[i]),
			.mask      (cfg.interrupt_mask[i]),
			.pin_set   (pin_set[i]),
			.clr       (req.clear_mask[i]),
			.link_in   (link[i+1]),
			.link_out  (link[i]),
			.co        (co[i]),
			.last_time (ltime[i])
		);
		assign fire[i]    = co[i].fire;
		assign pend_nx[i] = co[i].pend_nx;
		assign isr_nx[i]  = co[i].isr_nx;
	end

	// at most one cell fires, so or-ing the indexes gives the source
	always_comb begin
		fire_idx = '0;
		for (int i = 0; i < mfp_pkg::SRC_COUNT; i++) begin
			fire_idx = fire_idx | (fire[i] ? mfp_pkg::SRC_W'(i) : '0);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.ready) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fired_q  <= |fire;
			vector_q <= (|fire) ? {cfg.vector_base, fire_idx} : 8'd0;
			pend_q   <= pend_nx;
			isr_q    <= isr_nx;
		end
	end

	assign rsp.valid           = valid_q;
	assign rsp.irq_fired       = fired_q;
	assign rsp.vector_number   = vector_q;
	assign rsp.pending_bits    = pend_q;
	assign rsp.in_service_bits = isr_q;

	// only one source is delivered per beat
	a_one_fire: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(fire))
		else $error("more than one source delivered in a beat");

	// delivery needs an accepted beat with cpu level below six and no hold
	a_fire_gate: assert property (@(posedge clk) disable iff (!arst_n)
		|fire |-> take && bc.deliver_ok)
		else $error("delivery without an accepted deliverable beat");

	// a check whose scan ran off the bottom of the chain delivers nothing
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		take && bc.kind == mfp_pkg::REQ_CHECK && link[0].scan |-> !(|fire))
		else $error("check delivered with no candidate in the chain");

	// the delivered source leaves pending clear
	a_fired_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && fired_q |-> !pend_q[vector_q[mfp_pkg::SRC_W-1:0]])
		else $error("delivered source still pending");

endmodule

@@ dv/tb_mfp_interrupt_controller.sv @@
// self-checking testbench for the sixteen-source interrupt controller: directed
// beats for edges, priority, guard time and masking, then randomised phases
// depends on mfp_pkg, mfp_if and the mfp_interrupt_controller rtl
module tb_mfp_interrupt_controller;
	import mfp_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [SRC_W-1:0] SRC_OF_PIN [PIN_COUNT] =
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd6, 4'd7, 4'd14, 4'd15};

	typedef struct packed {
		mfp_req_t              kind;
		logic [PIN_W-1:0]      pin;
		logic                  level;
		logic [SRC_W-1:0]      src;
		logic [2:0]            ipl;
		logic                  hold;
		logic [TIME_W-1:0]     now;
		logic [SRC_COUNT-1:0]  clr;
	} irq_req_t;

	typedef struct packed {
		logic                  fired;
		logic [7:0]            vector;
		logic [SRC_COUNT-1:0]  pending;
		logic [SRC_COUNT-1:0]  in_service;
	} irq_outcome_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	mfp_req_if req_ch ();
	mfp_rsp_if rsp_ch ();

	mfp_interrupt_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// shadow of the controller: registers and state
	mfp_cfg_t             cfg_copy;
	logic [PIN_COUNT-1:0] pin_lvl;
	logic [SRC_COUNT-1:0] pend_bits;
	logic [SRC_COUNT-1:0] isr_bits;
	logic [TIME_W-1:0]    svc_start [SRC_COUNT];

	irq_outcome_t      outcome_q [$];
	logic [TIME_W-1:0] t_now;
	bit                idle_on;
	int                errors;
	int                beats_sent;
	int                irqs_seen;
	int                settings_used;
	int                stall_left;
	int                cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("mfp_interrupt_controller test failed");
			$finish;
		end
	end

	// guard distance: magnitude of the signed wrapping difference
	function automatic logic guard_clear(input logic [SRC_W-1:0] s, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] d;
		d = now - svc_start[s];
		if (d[TIME_W-1])
			d = -d;
		if (d[TIME_W-1])
			return 1'b1;
		return d >= {24'd0, cfg_copy.ack_guard_cycles};
	endfunction

	// deliver one source to the cpu if nothing stands in the way
	function automatic logic deliver(input logic [SRC_W-1:0] s, input logic [2:0] ipl,
			input logic hold, input logic [TIME_W-1:0] now, output logic [7:0] vector);
		logic [SRC_COUNT-1:0] sel;
		logic [SRC_COUNT-1:0] upper;
		sel = 16'd1 << s;
		upper = 16'hFFFF << s;
		vector = 8'd0;
		if ((cfg_copy.interrupt_enable & sel) == '0 || (pend_bits & sel) == '0 ||
				(cfg_copy.interrupt_mask & sel) == '0 || (isr_bits & upper) != '0 ||
				ipl >= IPL_LIMIT || hold)
			return 1'b0;
		pend_bits &= ~sel;
		if (cfg_copy.software_eoi)
			isr_bits |= sel;
		else
			isr_bits &= ~sel;
		vector = {cfg_copy.vector_base, s};
		svc_start[s] = now;
		return 1'b1;
	endfunction

	// advance the shadow by one request and give the result it must produce
	function automatic irq_outcome_t step_controller(input irq_req_t r);
		irq_outcome_t     o;
		logic [7:0]       m;
		logic [7:0]       cur;
		logic [7:0]       nw;
		logic [7:0]       vector;
		logic             fired;
		logic             done;
		logic [SRC_W-1:0] s;
		fired = 1'b0;
		done = 1'b0;
		vector = 8'd0;
		case (r.kind)
			REQ_PIN: begin
				m = 8'd1 << r.pin;
				cur = pin_lvl & m;
				nw = r.level ? m : 8'd0;
				// only a real level change counts, and only in the active sense
				if (cur != nw) begin
					if ((cur ^ (cfg_copy.active_edge & m)) == m &&
							(cfg_copy.pin_direction & m) == '0) begin
						s = SRC_OF_PIN[r.pin];
						if (cfg_copy.interrupt_enable[s])
							pend_bits[s] = 1'b1;
					end
					pin_lvl = (pin_lvl & ~m) | nw;
				end
			end
			REQ_INT: if (cfg_copy.interrupt_enable[r.src]) begin
				if (guard_clear(r.src, r.now))
					pend_bits[r.src] = 1'b1;
				fired = deliver(r.src, r.ipl, r.hold, r.now, vector);
			end
			REQ_CHECK: if (!r.hold) begin
				// scan from the top, stop at in-service or at the first candidate
				for (int i = SRC_COUNT - 1; i >= 0; i--) begin
					if (!done) begin
						if (isr_bits[i]) begin
							done = 1'b1;
						end else if (pend_bits[i] && cfg_copy.interrupt_mask[i]) begin
							fired = deliver(4'(i), r.ipl, r.hold, r.now, vector);
							done = 1'b1;
						end
					end
				end
			end
			default: begin
				isr_bits &= ~r.clr;
			end
		endcase
		o.fired = fired;
		o.vector = fired ? vector : 8'd0;
		o.pending = pend_bits;
		o.in_service = isr_bits;
		return o;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	task automatic compare_outcome();
		irq_outcome_t want;
		if (outcome_q.size() == 0) begin
			errors++;
			$display("%0t: result beat with nothing expected, expected none, actual %b %h %h %h",
				$time, rsp_ch.irq_fired, rsp_ch.vector_number, rsp_ch.pending_bits,
				rsp_ch.in_service_bits);
			return;
		end
		want = outcome_q.pop_front();
		check_field("irq_fired", 16'(want.fired), 16'(rsp_ch.irq_fired));
		check_field("vector_number", 16'(want.vector), 16'(rsp_ch.vector_number));
		check_field("pending_bits", want.pending, rsp_ch.pending_bits);
		check_field("in_service_bits", want.in_service, rsp_ch.in_service_bits);
		if (rsp_ch.irq_fired === 1'b1)
			irqs_seen++;
	endtask

	// result side: check each accepted beat, stall ready in bursts
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			compare_outcome();
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			stall_left = int'($urandom_range(0, 17));
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// one request beat; valid stays high afterwards until the next gap
	task automatic send_beat(input irq_req_t r);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= r.kind;
		req_ch.pin_index  <= r.pin;
		req_ch.pin_level  <= r.level;
		req_ch.irq_number <= r.src;
		req_ch.cpu_ipl    <= r.ipl;
		req_ch.mfp_hold   <= r.hold;
		req_ch.now_time   <= r.now;
		req_ch.clear_mask <= r.clr;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		outcome_q.push_back(step_controller(r));
		beats_sent++;
	endtask

	// every field random, the caller overrides what matters
	function automatic irq_req_t noise_item();
		irq_req_t r;
		r.kind  = mfp_req_t'($urandom_range(0, 3));
		r.pin   = PIN_W'($urandom);
		r.level = 1'($urandom);
		r.src   = SRC_W'($urandom);
		r.ipl   = 3'($urandom);
		r.hold  = 1'($urandom);
		r.now   = $urandom;
		r.clr   = SRC_COUNT'($urandom);
		return r;
	endfunction

	task automatic pin_beat(input logic [PIN_W-1:0] pin, input logic level);
		irq_req_t r;
		r = noise_item();
		r.kind = REQ_PIN;
		r.pin = pin;
		r.level = level;
		send_beat(r);
	endtask

	task automatic source_beat(input logic [SRC_W-1:0] src, input logic [2:0] ipl,
			input logic [TIME_W-1:0] now);
		irq_req_t r;
		r = noise_item();
		r.kind = REQ_INT;
		r.src = src;
		r.ipl = ipl;
		r.hold = 1'b0;
		r.now = now;
		send_beat(r);
	endtask

	task automatic check_beat(input logic [2:0] ipl, input logic hold);
		irq_req_t r;
		r = noise_item();
		r.kind = REQ_CHECK;
		r.ipl = ipl;
		r.hold = hold;
		r.now = t_now;
		send_beat(r);
	endtask

	task automatic clear_beat(input logic [SRC_COUNT-1:0] clr);
		irq_req_t r;
		r = noise_item();
		r.kind = REQ_CLEAR;
		r.clr = clr;
		send_beat(r);
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write with junk above the register width; psel stays up for back-to-back writes
	task automatic write_reg(input mfp_reg_t idx, input logic [31:0] val, input int width);
		logic [31:0] data;
		data = ($urandom << width) | val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_ACTIVE_EDGE: cfg_copy.active_edge      = data[7:0];
			REG_PIN_DIR:     cfg_copy.pin_direction    = data[7:0];
			REG_IRQ_ENABLE:  cfg_copy.interrupt_enable = data[15:0];
			REG_IRQ_MASK:    cfg_copy.interrupt_mask   = data[15:0];
			REG_VECTOR_BASE: cfg_copy.vector_base      = data[3:0];
			REG_SOFT_EOI:    cfg_copy.software_eoi     = data[0];
			REG_ACK_GUARD:   cfg_copy.ack_guard_cycles = data[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic apply_config(input mfp_cfg_t c);
		wait_idle();
		write_reg(REG_ACTIVE_EDGE, 32'(c.active_edge), 8);
		write_reg(REG_PIN_DIR, 32'(c.pin_direction), 8);
		write_reg(REG_IRQ_ENABLE, 32'(c.interrupt_enable), 16);
		write_reg(REG_IRQ_MASK, 32'(c.interrupt_mask), 16);
		write_reg(REG_VECTOR_BASE, 32'(c.vector_base), 4);
		write_reg(REG_SOFT_EOI, 32'(c.software_eoi), 1);
		write_reg(REG_ACK_GUARD, 32'(c.ack_guard_cycles), 8);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic mfp_cfg_t random_config();
		mfp_cfg_t c;
		c.active_edge      = PIN_COUNT'($urandom);
		c.pin_direction    = PIN_COUNT'($urandom & $urandom);
		c.interrupt_enable = SRC_COUNT'($urandom | $urandom);
		c.interrupt_mask   = SRC_COUNT'($urandom | $urandom);
		c.vector_base      = 4'($urandom);
		c.software_eoi     = 1'($urandom);
		case ($urandom_range(0, 2))
			0:       c.ack_guard_cycles = 8'h00;
			1:       c.ack_guard_cycles = 8'hFF;
			default: c.ack_guard_cycles = GUARD_W'($urandom);
		endcase
		return c;
	endfunction

	// mostly real pin toggles and requests with a moving clock, some noise
	function automatic irq_req_t random_item();
		irq_req_t r;
		int       pick;
		r = noise_item();
		pick = int'($urandom_range(0, 99));
		if (pick < 35) begin
			r.kind = REQ_PIN;
			if ($urandom_range(0, 9) < 8)
				r.level = ~pin_lvl[r.pin];
		end else if (pick < 65) begin
			r.kind = REQ_INT;
		end else if (pick < 90) begin
			r.kind = REQ_CHECK;
		end else begin
			r.kind = REQ_CLEAR;
			if ($urandom_range(0, 1))
				r.clr = 16'd1 << $urandom_range(0, 15);
		end
		r.ipl = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		r.hold = ($urandom_range(0, 6) == 0);
		if ($urandom_range(0, 19) == 0)
			t_now = $urandom;
		else
			t_now += $urandom_range(0, 300);
		r.now = t_now;
		return r;
	endfunction

	task automatic test_reset_state();
		check_beat(3'd0, 1'b0);
	endtask

	// active edge per pin, unchanged levels, output pins
	task automatic test_pin_edges();
		mfp_cfg_t c;
		c.active_edge      = 8'h0F;
		c.pin_direction    = 8'h20;
		c.interrupt_enable = 16'hFFFF;
		c.interrupt_mask   = 16'hFFFF;
		c.vector_base      = 4'hF;
		c.software_eoi     = 1'b1;
		c.ack_guard_cycles = 8'h00;
		apply_config(c);
		pin_beat(3'd0, 1'b1);
		pin_beat(3'd0, 1'b1);
		pin_beat(3'd7, 1'b1);
		pin_beat(3'd7, 1'b0);
		pin_beat(3'd5, 1'b1);
		pin_beat(3'd5, 1'b0);
		pin_beat(3'd6, 1'b1);
		pin_beat(3'd6, 1'b0);
	endtask

	// ipl and hold blocking, in-service priority, nesting, isr clears
	task automatic test_delivery();
		check_beat(3'd6, 1'b0);
		check_beat(3'd7, 1'b0);
		check_beat(3'd0, 1'b1);
		check_beat(3'd5, 1'b0);
		check_beat(3'd0, 1'b0);
		source_beat(4'd3, 3'd0, 32'd10);
		clear_beat(16'h8000);
		check_beat(3'd0, 1'b0);
		source_beat(4'd15, 3'd0, 32'd20);
		clear_beat(16'hFFFF);
	endtask

	// guard distance both ways, the most negative difference, disabled and masked sources
	task automatic test_guard();
		mfp_cfg_t c;
		c.active_edge      = 8'h00;
		c.pin_direction    = 8'hFF;
		c.interrupt_enable = 16'hBFFF;
		c.interrupt_mask   = 16'h7FFF;
		c.vector_base      = 4'h0;
		c.software_eoi     = 1'b0;
		c.ack_guard_cycles = 8'hFF;
		apply_config(c);
		source_beat(4'd4, 3'd0, 32'd1000);
		source_beat(4'd4, 3'd0, 32'd1100);
		source_beat(4'd4, 3'd0, 32'd900);
		source_beat(4'd4, 3'd0, 32'd1255);
		source_beat(4'd4, 3'd0, 32'h8000_04E7);
		source_beat(4'd14, 3'd0, 32'd5000);
		source_beat(4'd15, 3'd0, 32'd5000);
		source_beat(4'd13, 3'd7, 32'd5000);
		// pending source whose enable is then withdrawn stops the scan
		c.interrupt_enable = 16'h9FFF;
		apply_config(c);
		check_beat(3'd0, 1'b0);
		source_beat(4'd2, 3'd0, 32'd5000);
	endtask

	// phases of random beats, first two at the register extremes
	task automatic test_random_phases();
		mfp_cfg_t c;
		int       n;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					c = '1;
					c.pin_direction = 8'h00;
				end
				1: begin
					c = '0;
					c.pin_direction = 8'hFF;
				end
				default: begin
					c = random_config();
				end
			endcase
			apply_config(c);
			idle_on = (p == 0 || p == 2 || p == 4);
			n = (p == 1) ? 30 : ((p == 0) ? 80 : 85);
			for (int i = 0; i < n; i++) begin
				// hold the sender back once until every result is home
				if (p == 2 && i == n / 2)
					wait_idle();
				send_beat(random_item());
			end
		end
		idle_on = 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_PIN;
		req_ch.pin_index  = '0;
		req_ch.pin_level  = 1'b0;
		req_ch.irq_number = '0;
		req_ch.cpu_ipl    = '0;
		req_ch.mfp_hold   = 1'b0;
		req_ch.now_time   = '0;
		req_ch.clear_mask = '0;
		rsp_ch.ready      = 1'b0;
		idle_on           = 1'b0;
		cfg_copy          = '0;
		pin_lvl           = '0;
		pend_bits         = '0;
		isr_bits          = '0;
		t_now             = '0;
		for (int i = 0; i < SRC_COUNT; i++)
			svc_start[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_pin_edges();
		test_delivery();
		test_guard();
		test_random_phases();
		wait_idle();

		$display("covered %0d request beats under %0d register settings, %0d deliveries",
			beats_sent, settings_used, irqs_seen);
		$display("pin edges, internal requests, priority scans and isr clears, %0d mismatches",
			errors);
		if (errors == 0)
			$display("mfp_interrupt_controller test passed");
		else
			$display("mfp_interrupt_controller test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/mfp_pkg.sv
src/mfp_if.sv
src/mfp_cfg.sv
src/mfp_gpip.sv
src/mfp_cell.sv
src/mfp_interrupt_controller.sv
dv/tb_mfp_interrupt_controller.sv
